/* hdl/framed_status_deframer_core_defines.svh */
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Shared concurrent assertion forms for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef FRAMED_STATUS_DEFRAMER_CORE_DEFINES_SVH
`define FRAMED_STATUS_DEFRAMER_CORE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define FSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define FSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/fsd_pkg.sv */
// ----------------------------------------------------------------------------
// Deframer package
// Constants, result type and the range check shared by the deframer modules.
// ----------------------------------------------------------------------------
package fsd_pkg;

	localparam logic [7:0]  HDR_BYTE   = 8'hAA;
	localparam logic [7:0]  TAIL_BYTE  = 8'hBB;
	localparam logic [30:0] LIMIT_BITS = 31'h4334_0000;
	localparam logic [30:0] INF_BITS   = 31'h7F80_0000;

	localparam logic [1:0] MODE_A = 2'd0;
	localparam logic [1:0] MODE_B = 2'd1;
	localparam logic [1:0] MODE_C = 2'd2;
	localparam logic [1:0] MODE_D = 2'd3;

	typedef struct packed {
		logic [31:0] pitch_bits;
		logic [31:0] yaw_bits;
		logic [31:0] time_bits;
		logic [1:0]  mode_code;
		logic        blue_side;
		logic        outpost_flag;
		logic [7:0]  firing_rate;
		logic        pitch_zeroed;
		logic        yaw_zeroed;
	} result_t;

	// Raw frame handed from the front part to the back part.
	typedef struct packed {
		logic [31:0] pitch_raw;
		logic [31:0] yaw_raw;
		logic [31:0] time_raw;
		logic [7:0]  status;
		logic [7:0]  rate;
	} frame_t;

	// Magnitude above 180, infinity included, NaN excluded.
	function automatic logic beyond_limit(input logic [31:0] bits);
		return (bits[30:0] > LIMIT_BITS) && (bits[30:0] <= INF_BITS);
	endfunction

endpackage

/* hdl/fsd_stream_if.sv */
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one word of a parameterized payload width per handshake.
// ----------------------------------------------------------------------------
interface fsd_stream_if #(
	parameter int W = 8
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hdl/framed_status_deframer_core.sv */
// Once the tail byte is accepted, the frame is registered in the front part, then in the back part.
// Throughput: one byte word per cycle while rx.ready is high; a frame takes sixteen bytes.
// The front frame register and the back result register decouple the parts,
// so bytes keep flowing while a result waits unless both registers are full.
// Reset (arst_n low, asynchronous) returns to header search with mode zero.
// ----------------------------------------------------------------------------
// Framed status deframer core
// Finds header/tail framed 16-byte status frames in a byte stream and
// unpacks angles, time, status fields and firing rate.
// ----------------------------------------------------------------------------
`include "framed_status_deframer_core_defines.svh"

module framed_status_deframer_core (
	input logic       clk,
	input logic       arst_n,
	fsd_stream_if.sink   rx,
	fsd_stream_if.source res
);
	import fsd_pkg::*;

	// Handoff between the parts: one registered frame, the short queue.
	logic    frm_valid;
	logic    frm_ready;
	frame_t  frm;
	result_t res_word;

	// Front: track position, store payload, drop bad tails.
	fsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx.valid),
		.in_ready  (rx.ready),
		.in_byte   (rx.data),
		.frm_valid (frm_valid),
		.frm_ready (frm_ready),
		.frm       (frm)
	);

	// Back: check range, decode mode, hold the result word.
	fsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.frm_valid (frm_valid),
		.frm_ready (frm_ready),
		.frm       (frm),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.res       (res_word)
	);

	assign res.data = res_word;

	// A stalled result word must stay put.
	`FSD_ASSERT_NEXT(a_res_hold, clk, arst_n, res.valid && !res.ready, res.valid && $stable(res.data), "result changed while stalled")
	// Zeroed flags imply a zero angle.
	`FSD_ASSERT_IMP(a_pitch_zero, clk, arst_n, res.valid && res_word.pitch_zeroed, res_word.pitch_bits == 32'd0, "pitch flagged but not zero")
	`FSD_ASSERT_IMP(a_yaw_zero, clk, arst_n, res.valid && res_word.yaw_zeroed, res_word.yaw_bits == 32'd0, "yaw flagged but not zero")
endmodule

/* hdl/fsd_front.sv */
// ----------------------------------------------------------------------------
// Deframer front part
// Tracks frame position, stores payload bytes, emits complete frames.
// ----------------------------------------------------------------------------
module fsd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_byte,
	output logic           frm_valid,
	input  logic           frm_ready,
	output fsd_pkg::frame_t frm
);
	import fsd_pkg::*;

	logic       in_frame_q;
	logic [3:0] pos_q;
	logic [7:0] pay_q [0:13];
	logic       frm_valid_q;
	frame_t     frm_q;
	logic       take;
	logic       tail_ok;

	// Accept while the frame register is free or draining this cycle.
	assign in_ready  = !frm_valid_q || frm_ready;
	assign take      = in_valid && in_ready;
	assign tail_ok   = in_frame_q && (pos_q == 4'd14) && (in_byte == TAIL_BYTE);
	assign frm_valid = frm_valid_q;
	assign frm       = frm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= 4'd0;
		end else if (take) begin
			if (in_byte == HDR_BYTE) begin
				in_frame_q <= 1'b1;
				pos_q      <= 4'd0;
			end else if (in_frame_q) begin
				if (pos_q < 4'd14) begin
					pos_q <= pos_q + 4'd1;
				end else begin
					in_frame_q <= 1'b0;
					pos_q      <= 4'd0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_byte != HDR_BYTE && in_frame_q && pos_q < 4'd14) begin
			pay_q[pos_q] <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frm_valid_q <= 1'b0;
		end else if (take && tail_ok) begin
			frm_valid_q <= 1'b1;
		end else if (frm_ready) begin
			frm_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && tail_ok) begin
			frm_q.pitch_raw <= {pay_q[3], pay_q[2], pay_q[1], pay_q[0]};
			frm_q.yaw_raw   <= {pay_q[7], pay_q[6], pay_q[5], pay_q[4]};
			frm_q.status    <= pay_q[8];
			frm_q.time_raw  <= {pay_q[12], pay_q[11], pay_q[10], pay_q[9]};
			frm_q.rate      <= pay_q[13];
		end
	end
endmodule

/* hdl/fsd_back.sv */
// ----------------------------------------------------------------------------
// Deframer back part
// Range-checks angles, decodes status and holds the mode across frames.
// ----------------------------------------------------------------------------
module fsd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            frm_valid,
	output logic            frm_ready,
	input  fsd_pkg::frame_t frm,
	output logic            res_valid,
	input  logic            res_ready,
	output fsd_pkg::result_t res
);
	import fsd_pkg::*;

	logic [1:0] mode_q;
	logic [1:0] mode_nxt;
	logic       res_valid_q;
	result_t    res_q;
	logic       pz;
	logic       yz;
	logic       take;

	assign frm_ready = !res_valid_q || res_ready;
	assign take      = frm_valid && frm_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign pz        = beyond_limit(frm.pitch_raw);
	assign yz        = beyond_limit(frm.yaw_raw);

	always_comb begin
		unique case (frm.status[3:1])
			3'b100:  mode_nxt = MODE_A;
			3'b011:  mode_nxt = MODE_B;
			3'b001:  mode_nxt = MODE_C;
			3'b010:  mode_nxt = MODE_D;
			default: mode_nxt = mode_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_A;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				mode_q      <= mode_nxt;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.pitch_bits   <= pz ? 32'd0 : frm.pitch_raw;
			res_q.yaw_bits     <= yz ? 32'd0 : frm.yaw_raw;
			res_q.time_bits    <= frm.time_raw;
			res_q.mode_code    <= mode_nxt;
			res_q.blue_side    <= frm.status[4];
			res_q.outpost_flag <= frm.status[5];
			res_q.firing_rate  <= frm.rate;
			res_q.pitch_zeroed <= pz;
			res_q.yaw_zeroed   <= yz;
		end
	end
endmodule

/* test/tb_framed_status_deframer_core.sv */
// ----------------------------------------------------------------------------
// Deframer core regression bench
// Drives byte words into framed_status_deframer_core and predicts each
// unpacked result word. Covers directed edge frames, random frames, noise
// and broken frames under random idling, backpressure and drain pauses.
// ----------------------------------------------------------------------------
module tb_framed_status_deframer_core;
	import fsd_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int N_RANDOM    = 330;

	logic clk;
	logic arst_n;

	fsd_stream_if #(.W(8))               rx_if ();
	fsd_stream_if #(.W($bits(result_t))) res_if ();

	framed_status_deframer_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if)
	);

	// Deframer prediction state
	logic        frm_open;
	logic [3:0]  frm_pos;
	logic [7:0]  frm_bytes [14];
	logic [1:0]  mode_held;
	result_t     frames_due [$];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_cycles;
	int mismatches;
	int cycles;

	always #5 clk = ~clk;

	// Advance the frame tracker by one byte and queue any finished frame.
	task automatic track_byte(input logic [7:0] b);
		logic [31:0] p, y, t;
		logic [7:0]  st;
		result_t     r;
		if (b == HDR_BYTE) begin
			frm_open = 1'b1;
			frm_pos  = '0;
		end else if (frm_open) begin
			if (frm_pos < 4'd14) begin
				frm_bytes[frm_pos] = b;
				frm_pos = frm_pos + 4'd1;
			end else begin
				frm_open = 1'b0;
				frm_pos  = '0;
				if (b == TAIL_BYTE) begin
					p  = {frm_bytes[3], frm_bytes[2], frm_bytes[1], frm_bytes[0]};
					y  = {frm_bytes[7], frm_bytes[6], frm_bytes[5], frm_bytes[4]};
					st = frm_bytes[8];
					t  = {frm_bytes[12], frm_bytes[11], frm_bytes[10], frm_bytes[9]};
					case (st[3:1])
						3'b100: mode_held = MODE_A;
						3'b011: mode_held = MODE_B;
						3'b001: mode_held = MODE_C;
						3'b010: mode_held = MODE_D;
						default: ;
					endcase
					r.pitch_zeroed = (p[30:0] > LIMIT_BITS) && (p[30:0] <= INF_BITS);
					r.yaw_zeroed   = (y[30:0] > LIMIT_BITS) && (y[30:0] <= INF_BITS);
					r.pitch_bits   = r.pitch_zeroed ? 32'h0 : p;
					r.yaw_bits     = r.yaw_zeroed ? 32'h0 : y;
					r.time_bits    = t;
					r.mode_code    = mode_held;
					r.blue_side    = st[4];
					r.outpost_flag = st[5];
					r.firing_rate  = frm_bytes[13];
					frames_due.push_back(r);
				end
			end
		end
	endtask

	// Offer one byte word, sometimes after a random gap, and hold until accepted.
	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			rx_if.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.data  <= b;
		do @(posedge clk); while (!rx_if.ready);
		track_byte(b);
	endtask

	// Payload layout: pitch, yaw, status, time, rate from byte 0 up.
	task automatic send_frame(input logic [111:0] pl, input logic [7:0] tail);
		send_byte(HDR_BYTE);
		for (int k = 0; k < 14; k++)
			send_byte(pl[8*k +: 8]);
		send_byte(tail);
	endtask

	function automatic logic [111:0] pack_frame(input logic [31:0] p, input logic [31:0] y,
			input logic [7:0] st, input logic [31:0] t, input logic [7:0] rate);
		return {rate, t, st, y, p};
	endfunction

	// Pick an angle word that lands on the interesting ranges.
	function automatic logic [31:0] pick_angle();
		logic [31:0] a;
		case ($urandom_range(9))
			5:       a = $urandom_range(32'h7F7F_FFFF, 32'h4334_0001);
			6:       a = 32'h7F80_0000;
			7:       a = $urandom_range(32'h7FFF_FFFF, 32'h7F80_0001);
			8:       a = 32'h4334_0000;
			9:       a = $urandom;
			default: a = $urandom_range(32'h4334_0000, 0);
		endcase
		a[31] = 1'($urandom_range(1));
		return a;
	endfunction

	// Replace stray header bytes so the frame survives.
	function automatic logic [111:0] scrub(input logic [111:0] pl);
		for (int k = 0; k < 14; k++)
			if (pl[8*k +: 8] == HDR_BYTE)
				pl[8*k +: 8] = 8'hAB;
		return pl;
	endfunction

	function automatic logic [111:0] random_frame();
		return scrub(pack_frame(pick_angle(), pick_angle(), 8'($urandom), $urandom,
			8'($urandom)));
	endfunction

	task automatic wait_drain();
		while (frames_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_directed();
		// in-range limit pitch, just-over negative yaw, all ones elsewhere
		send_frame(pack_frame(32'h4334_0000, 32'hC334_0001, 8'hFF, 32'hFFFF_FFFF, 8'hFF),
			TAIL_BYTE);
		// infinity zeroed, NaN passed, tail byte inside payload, zero bytes
		send_frame(pack_frame(32'hFF80_0000, 32'h7FC0_0000, 8'b0000_1000, 32'hBBBB_BBBB,
			8'h00), TAIL_BYTE);
		// noise while searching, then a header restarting a frame in progress
		send_byte(8'h00);
		send_byte(TAIL_BYTE);
		send_byte(HDR_BYTE);
		send_byte(8'h12);
		send_byte(8'h34);
		send_frame(pack_frame(32'h0, 32'h8000_0000, 8'b0000_0110, 32'h3F80_0000, 8'h5A),
			TAIL_BYTE);
		// wrong tail drops, header at tail position restarts
		send_frame(pack_frame(32'h1, 32'h2, 8'b0000_0010, 32'h3, 8'h4), 8'h00);
		send_frame(pack_frame(32'h1, 32'h2, 8'b0000_0100, 32'h3, 8'h4), HDR_BYTE);
		for (int k = 0; k < 15; k++)
			send_byte(k == 14 ? TAIL_BYTE : 8'h00);
		// remaining mode patterns plus an unmatched one that holds
		send_frame(pack_frame(32'h1, 32'h2, 8'b0000_0010, 32'h3, 8'h4), TAIL_BYTE);
		send_frame(pack_frame(32'h1, 32'h2, 8'b0000_0100, 32'h3, 8'h4), TAIL_BYTE);
		send_frame(pack_frame(32'h1, 32'h2, 8'b0000_1110, 32'h3, 8'h4), TAIL_BYTE);
	endtask

	task automatic test_random(input int n_items);
		int sent;
		int cut;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(9))
				0: begin
					send_byte(8'($urandom));
					sent++;
				end
				1: begin
					// truncated frame, restarted by the next header
					cut = $urandom_range(14);
					send_byte(HDR_BYTE);
					for (int k = 0; k < cut; k++)
						send_byte(8'($urandom));
					sent += cut + 1;
				end
				2: begin
					send_frame(random_frame(), 8'($urandom));
					sent += 16;
				end
				default: begin
					send_frame(random_frame(), TAIL_BYTE);
					sent += 16;
				end
			endcase
		end
	endtask

	// Stall the result side long enough to back up the input.
	task automatic test_backpressure();
		hold_cycles = 150;
		for (int f = 0; f < 4; f++)
			send_frame(random_frame(), TAIL_BYTE);
		wait_drain();
	endtask

	// Byte source
	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		rx_if.valid  <= 1'b0;
		rx_if.data   <= '0;
		frm_open      = 1'b0;
		frm_pos       = '0;
		mode_held     = MODE_A;
		send_idle_pct = 11;
		recv_idle_pct = 45;
		hold_cycles   = 0;
		mismatches    = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(N_RANDOM / 3);
		wait_drain();
		send_idle_pct = 45;
		recv_idle_pct = 11;
		test_random(N_RANDOM / 3);
		test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(N_RANDOM / 3);

		rx_if.valid <= 1'b0;
		wait_drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && frames_due.size() == 0) begin
			$display("framed_status_deframer_core regression: pass");
		end else begin
			$display("framed_status_deframer_core regression: fail");
		end
		$finish;
	end

	// Result sink: random stalls plus the long hold-off
	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				res_if.ready <= 1'b0;
				hold_cycles--;
			end else begin
				res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Compare each accepted result word with the oldest finished frame.
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && res_if.valid && res_if.ready) begin
			got = result_t'(res_if.data);
			if (frames_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", got);
			end else begin
				want = frames_due.pop_front();
				if (got.pitch_bits !== want.pitch_bits || got.yaw_bits !== want.yaw_bits ||
						got.time_bits !== want.time_bits ||
						got.mode_code !== want.mode_code ||
						got.blue_side !== want.blue_side ||
						got.outpost_flag !== want.outpost_flag ||
						got.firing_rate !== want.firing_rate ||
						got.pitch_zeroed !== want.pitch_zeroed ||
						got.yaw_zeroed !== want.yaw_zeroed) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %h actual %h", want, got);
				end
			end
		end
	end

	// Watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("framed_status_deframer_core regression: fail");
				$finish;
			end
		end
	end

endmodule
